// ===== rtl/fpba_pkg.sv =====
`timescale 1ns / 1ps
package fpba_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_WIDTH = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 5;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int TDATA_W    = 24;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BLOCKS);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

	typedef struct packed {
		logic capture;
		logic scan_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/fpba_ctrl.sv =====
`timescale 1ns / 1ps
module fpba_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_command,
	output logic                   s_tready,
	input  fpba_pkg::dp_status_t   status,
	output fpba_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd.capture   = (state_q == ST_IDLE) && s_tvalid;
		cmd.scan_step = (state_q == ST_SCAN) && !status.scan_done;
		cmd.finish    = (state_q == ST_FINISH) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= (s_command == fpba_pkg::CMD_ALLOC) ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (status.scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/fpba_datapath.sv =====
`timescale 1ns / 1ps
module fpba_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpba_pkg::ctrl_cmd_t                 cmd,
	output fpba_pkg::dp_status_t                status,
	input  logic                                s_command,
	input  logic [fpba_pkg::IDX_W-1:0]          s_block_index,
	input  logic [fpba_pkg::SIZE_WIDTH-1:0]     s_size_value,
	input  logic                                cfg_valid,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic                                m_granted,
	output logic [fpba_pkg::IDX_W-1:0]          m_chosen_index,
	output logic [fpba_pkg::SIZE_WIDTH-1:0]     m_remaining_size
);

	logic [fpba_pkg::SIZE_WIDTH-1:0] block_free_q [fpba_pkg::MAX_BLOCKS];

	logic [fpba_pkg::MODE_W-1:0]     fit_mode_q;
	logic [fpba_pkg::CNT_W-1:0]      block_count_q;

	logic                            cmd_q;
	logic [fpba_pkg::IDX_W-1:0]      idx_q;
	logic [fpba_pkg::SIZE_WIDTH-1:0] req_q;
	logic [fpba_pkg::CNT_W-1:0]      scan_q;
	logic                            found_q;
	logic [fpba_pkg::IDX_W-1:0]      pick_q;
	logic [fpba_pkg::SIZE_WIDTH-1:0] best_q;

	logic                            out_valid_q;
	logic                            out_granted_q;
	logic [fpba_pkg::IDX_W-1:0]      out_index_q;
	logic [fpba_pkg::SIZE_WIDTH-1:0] out_size_q;

	logic [fpba_pkg::CNT_W-1:0]      limit;
	logic [fpba_pkg::SIZE_WIDTH-1:0] cur_size;
	logic                            fits;
	logic                            take;
	logic [fpba_pkg::SIZE_WIDTH-1:0] reduced;

	assign limit    = (block_count_q > fpba_pkg::MAX_COUNT) ? fpba_pkg::MAX_COUNT : block_count_q;
	assign cur_size = block_free_q[scan_q[fpba_pkg::IDX_W-1:0]];
	assign fits     = (cur_size >= req_q);
	assign reduced  = best_q - req_q;

	assign status.scan_done = (scan_q >= limit);
	assign status.out_free  = !out_valid_q || m_tready;

	// first fit (and the unused code 3) keeps its first hit, best/worst keep comparing
	always_comb begin
		take = 1'b0;
		if (fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				unique case (fit_mode_q)
					fpba_pkg::FIT_BEST:  take = (best_q > cur_size);
					fpba_pkg::FIT_WORST: take = (best_q < cur_size);
					default:             take = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= fpba_pkg::FIT_FIRST;
			block_count_q <= fpba_pkg::MAX_COUNT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fpba_pkg::REG_FIT_MODE:    fit_mode_q    <= cfg_data[fpba_pkg::MODE_W-1:0];
				fpba_pkg::REG_BLOCK_COUNT: block_count_q <= cfg_data[fpba_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= s_command;
			idx_q  <= s_block_index;
			req_q  <= s_size_value;
			pick_q <= '0;
			best_q <= '0;
		end else if (cmd.scan_step && take) begin
			pick_q <= scan_q[fpba_pkg::IDX_W-1:0];
			best_q <= cur_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fpba_pkg::MAX_BLOCKS; i++) begin
				block_free_q[i] <= '0;
			end
		end else if (cmd.finish) begin
			if (cmd_q == fpba_pkg::CMD_LOAD) begin
				block_free_q[idx_q] <= req_q;
			end else if (found_q) begin
				block_free_q[pick_q] <= reduced;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (cmd_q == fpba_pkg::CMD_LOAD) begin
				out_granted_q <= 1'b1;
				out_index_q   <= idx_q;
				out_size_q    <= req_q;
			end else if (found_q) begin
				out_granted_q <= 1'b1;
				out_index_q   <= pick_q;
				out_size_q    <= reduced;
			end else begin
				out_granted_q <= 1'b0;
				out_index_q   <= '0;
				out_size_q    <= '0;
			end
		end
	end

	assign m_tvalid         = out_valid_q;
	assign m_granted        = out_granted_q;
	assign m_chosen_index   = out_index_q;
	assign m_remaining_size = out_size_q;

`ifndef SYNTHESIS
	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result written over an untaken beat");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (scan_q < limit))
		else $error("scan stepped past the searched entries");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && cmd_q == fpba_pkg::CMD_ALLOC && !found_q) |=>
		(!out_granted_q && out_index_q == '0 && out_size_q == '0))
		else $error("refused request reported nonzero fields");

	a_pick_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && cmd_q == fpba_pkg::CMD_ALLOC && found_q) |-> (best_q >= req_q))
		else $error("chosen entry smaller than request");
`endif

endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
`timescale 1ns / 1ps
// Free-size table allocator over 16 entries. A beat with tuser=0 loads block_index with
// size_value; a beat with tuser=1 searches entries 0..block_count-1 (clamped to 16) for
// one with free size >= size_value, picking by fit_mode (0 first, 1 best, 2 worst, 3 as
// first; ties to lowest index), subtracts the request and reports granted, index and
// remaining size. Every beat in gives exactly one beat out. A load goes straight to the
// write-back; an allocate first runs a sequential scan that reads one table entry per
// cycle before the write-back. The write-back waits while the previous result beat is
// still untaken; the output register holds a result while the next beat is taken.
// Configuration writes belong to idle periods only.
// The block itself does not enforce this.
module fit_policy_block_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fpba_pkg::TDATA_W-1:0]        s_tdata,   // [3:0] block_index, [19:4] size_value
	input  logic                                s_tuser,   // [0] command
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fpba_pkg::TDATA_W-1:0]        m_tdata,   // [3:0] chosen_index, [19:4] remaining_size
	output logic                                m_tuser,   // [0] granted
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PAD_W = fpba_pkg::TDATA_W - fpba_pkg::IDX_W - fpba_pkg::SIZE_WIDTH;

	fpba_pkg::ctrl_cmd_t  cmd;
	fpba_pkg::dp_status_t status;

	logic [fpba_pkg::IDX_W-1:0]      chosen_index;
	logic [fpba_pkg::SIZE_WIDTH-1:0] remaining_size;

	assign cfg_ready = 1'b1;

	fpba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_command (s_tuser),
		.s_tready  (s_tready),
		.status    (status),
		.cmd       (cmd)
	);

	fpba_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.s_command        (s_tuser),
		.s_block_index    (s_tdata[fpba_pkg::IDX_W-1:0]),
		.s_size_value     (s_tdata[fpba_pkg::IDX_W +: fpba_pkg::SIZE_WIDTH]),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_granted        (m_tuser),
		.m_chosen_index   (chosen_index),
		.m_remaining_size (remaining_size)
	);

	assign m_tdata = {{PAD_W{1'b0}}, remaining_size, chosen_index};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		logic                       cmd;
		logic [fpba_pkg::IDX_W-1:0] blk;
		logic [15:0]                amount;
	} alloc_req_t;

	typedef struct {
		logic                       granted;
		logic [fpba_pkg::IDX_W-1:0] blk;
		logic [15:0]                rest;
	} alloc_resp_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [fpba_pkg::TDATA_W-1:0]    s_tdata = '0;
	logic                            s_tuser = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [fpba_pkg::TDATA_W-1:0]    m_tdata;
	logic                            m_tuser;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	fit_policy_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the allocator
	logic [fpba_pkg::SIZE_WIDTH-1:0] free_table [fpba_pkg::MAX_BLOCKS];
	logic [fpba_pkg::MODE_W-1:0]     model_mode = fpba_pkg::FIT_FIRST;
	logic [fpba_pkg::CNT_W-1:0]      model_count = fpba_pkg::MAX_COUNT;

	alloc_req_t  pending_beats [$];
	alloc_resp_t expected_results [$];
	logic [15:0] loaded_sizes [fpba_pkg::MAX_BLOCKS];

	int beats_sent = 0;
	int beats_taken = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 4;
	int gap_left = 0;
	int ready_run = 0;
	int stall_run = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic alloc_resp_t predict_allocation(alloc_req_t req);
		alloc_resp_t r;
		int lim;
		bit found;
		int pick;
		r = '{granted: 1'b0, blk: '0, rest: '0};
		if (req.cmd == fpba_pkg::CMD_LOAD) begin
			free_table[req.blk] = req.amount;
			r = '{granted: 1'b1, blk: req.blk, rest: req.amount};
			return r;
		end
		lim = (model_count > fpba_pkg::MAX_COUNT) ? fpba_pkg::MAX_BLOCKS : int'(model_count);
		found = 1'b0;
		pick = 0;
		for (int j = 0; j < lim; j++) begin
			if (free_table[j] >= req.amount) begin
				if (!found) begin
					found = 1'b1;
					pick = j;
					if (model_mode != fpba_pkg::FIT_BEST && model_mode != fpba_pkg::FIT_WORST)
						break;
				end else if (model_mode == fpba_pkg::FIT_BEST) begin
					if (free_table[pick] > free_table[j])
						pick = j;
				end else if (model_mode == fpba_pkg::FIT_WORST) begin
					if (free_table[pick] < free_table[j])
						pick = j;
				end
			end
		end
		if (found) begin
			free_table[pick] = free_table[pick] - req.amount;
			r = '{granted: 1'b1, blk: fpba_pkg::IDX_W'(pick), rest: free_table[pick]};
		end
		return r;
	endfunction

	// sender: bursts of beats separated by random gaps
	always @(negedge clk) begin : drive_requests
		alloc_req_t nb;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && beats_taken != beats_sent)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				nb = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, nb.amount, nb.blk};
				s_tuser <= nb.cmd;
				beats_sent++;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: alternating ready runs and stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (ready_run == 0 && stall_run == 0) begin
				ready_run = $urandom_range(1, 40);
				stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			end
			if (stall_run > 0) begin
				stall_run--;
				m_tready <= 1'b0;
			end else begin
				ready_run--;
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch_beats
		alloc_req_t req;
		alloc_resp_t got;
		alloc_resp_t exp;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fpba_pkg::REG_FIT_MODE:    model_mode = cfg_data[fpba_pkg::MODE_W-1:0];
					fpba_pkg::REG_BLOCK_COUNT: model_count = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				req = '{cmd: s_tuser, blk: s_tdata[3:0], amount: s_tdata[19:4]};
				expected_results.push_back(predict_allocation(req));
				beats_taken++;
			end
			if (m_tvalid && m_tready) begin
				got = '{granted: m_tuser, blk: m_tdata[3:0], rest: m_tdata[19:4]};
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: granted %0d index %0d rest %0d",
						got.granted, got.blk, got.rest);
					mismatches++;
				end else begin
					exp = expected_results.pop_front();
					if (got.granted !== exp.granted) begin
						$error("granted: expected %0d, got %0d", exp.granted, got.granted);
						mismatches++;
					end
					if (got.blk !== exp.blk) begin
						$error("chosen_index: expected %0d, got %0d", exp.blk, got.blk);
						mismatches++;
					end
					if (got.rest !== exp.rest) begin
						$error("remaining_size: expected %0d, got %0d", exp.rest, got.rest);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [fpba_pkg::CFG_IDX_W-1:0] idx,
			input logic [fpba_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_beat(input logic cmd, input int blk, input int amount);
		pending_beats.push_back('{cmd: cmd, blk: fpba_pkg::IDX_W'(blk), amount: 16'(amount)});
		if (cmd == fpba_pkg::CMD_LOAD)
			loaded_sizes[blk] = 16'(amount);
	endtask

	// random traffic, requests biased toward sizes that were loaded
	task automatic add_random(input int n);
		int blk;
		int amount;
		int pick;
		for (int i = 0; i < n; i++) begin
			blk = $urandom_range(0, fpba_pkg::MAX_BLOCKS - 1);
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 99) < 35) begin
				case (pick)
					0: amount = 0;
					1: amount = 16'hFFFF;
					2: amount = $urandom_range(0, 65535);
					default: amount = $urandom_range(1, 2000);
				endcase
				push_beat(fpba_pkg::CMD_LOAD, blk, amount);
			end else begin
				case (pick)
					0: amount = 0;
					1: amount = $urandom_range(0, 65535);
					2, 3: amount = loaded_sizes[$urandom_range(0, fpba_pkg::MAX_BLOCKS - 1)];
					4: amount = loaded_sizes[$urandom_range(0, fpba_pkg::MAX_BLOCKS - 1)] + 16'd1;
					default: amount = $urandom_range(1, 600);
				endcase
				push_beat(fpba_pkg::CMD_ALLOC, blk, amount);
			end
		end
	endtask

	// wait until every queued beat has been sent and has come back, then let the block settle
	task automatic drain();
		while (!(pending_beats.size() == 0 && beats_taken == beats_sent &&
				expected_results.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic phase(input logic [fpba_pkg::CFG_DATA_W-1:0] mode_val,
			input logic [fpba_pkg::CFG_DATA_W-1:0] count_val, input int n);
		write_reg(fpba_pkg::REG_FIT_MODE, mode_val);
		write_reg(fpba_pkg::REG_BLOCK_COUNT, count_val);
		add_random(n);
		drain();
	endtask

	initial begin
		for (int i = 0; i < fpba_pkg::MAX_BLOCKS; i++) begin
			free_table[i] = '0;
			loaded_sizes[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first fit over the whole table, starting from an empty table
		write_reg(fpba_pkg::REG_FIT_MODE, fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_FIRST));
		write_reg(fpba_pkg::REG_BLOCK_COUNT, fpba_pkg::CFG_DATA_W'(fpba_pkg::MAX_COUNT));
		push_beat(fpba_pkg::CMD_ALLOC, 0, 0);      // zero request fits an empty entry
		push_beat(fpba_pkg::CMD_ALLOC, 15, 1);     // refused
		push_beat(fpba_pkg::CMD_LOAD, 15, 16'hFFFF);
		push_beat(fpba_pkg::CMD_LOAD, 0, 0);
		push_beat(fpba_pkg::CMD_LOAD, 3, 40);
		push_beat(fpba_pkg::CMD_LOAD, 7, 40);
		push_beat(fpba_pkg::CMD_LOAD, 9, 100);
		push_beat(fpba_pkg::CMD_LOAD, 12, 20);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 30);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 16'hFFFF);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 0);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 16'h8000);
		drain();

		// best fit, including a tie between equal sizes
		write_reg(fpba_pkg::REG_FIT_MODE, fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_BEST));
		push_beat(fpba_pkg::CMD_ALLOC, 0, 15);
		push_beat(fpba_pkg::CMD_LOAD, 4, 40);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 35);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 0);
		add_random(60);
		drain();

		// worst fit with a tie on the largest entry
		write_reg(fpba_pkg::REG_FIT_MODE, fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_WORST));
		push_beat(fpba_pkg::CMD_LOAD, 1, 16'hFFFE);
		push_beat(fpba_pkg::CMD_LOAD, 6, 16'hFFFE);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 10);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 0);
		add_random(60);
		drain();

		// unused policy code acts as first fit
		write_reg(fpba_pkg::REG_FIT_MODE, 5'd3);
		write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'd8);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 0);
		add_random(50);
		drain();

		// zero count refuses every allocation
		write_reg(fpba_pkg::REG_FIT_MODE, fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_WORST));
		write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'd0);
		push_beat(fpba_pkg::CMD_ALLOC, 0, 0);
		add_random(30);
		drain();

		phase(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_FIRST), 5'd1, 40);
		phase(5'b11101, 5'd31, 60);      // upper data bits set; count above the table
		phase(5'b11110, 5'd17, 50);
		phase(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_BEST), 5'd5, 50);
		phase(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_FIRST), 5'd16, 40);
		for (int k = 0; k < 2; k++)
			phase(fpba_pkg::CFG_DATA_W'($urandom_range(0, 3)),
				fpba_pkg::CFG_DATA_W'($urandom_range(0, 31)), 40);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
